// ===== sv/bdq_pkg.sv =====
// shared constants for the bounded deque with search
// operation and status codes, fixed field widths, default capacity
`timescale 1ns / 1ps

package bdq_pkg;

  // default ring depth
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int POS_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP_HEAD = 3'd2;
  localparam logic [OP_W-1:0] OP_DROP_TAIL = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE   = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== sv/bdq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bdq_ctrl.sv =====
// deque control: ring pointers, count, order flag, search sequencer
// depends on bdq_pkg; drives the element ram
`timescale 1ns / 1ps

module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [OP_W-1:0]             in_operation,
  input  logic signed [VAL_W-1:0]     in_value,
  output logic                        out_valid,
  output logic [ST_W-1:0]             out_status,
  output logic [POS_W-1:0]            out_position,
  output logic [POS_W-1:0]            out_occupancy,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [VAL_W-1:0]            mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [VAL_W-1:0]            mem_rdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  // ring arithmetic modulo the capacity
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return IDX_W'(s);
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_W'(CAPACITY - 1) : a - 1'b1;
  endfunction

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rev_r, rev_nxt;
  logic [VAL_W-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]   rd_pos_r, rd_pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]   out_occ_r, out_occ_nxt;

  logic             accept;
  logic             is_empty;
  logic             is_full;
  logic             low_side;
  logic             issue;
  logic             hit;
  logic             last_beat;
  logic [IDX_W-1:0] high_slot;
  logic [IDX_W-1:0] last_slot;

  assign accept    = start && (state_r == S_IDLE);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign high_slot = ring_add(front_r, count_r);
  assign last_slot = ring_add(front_r, count_r - 1'b1);
  assign issue     = (state_r == S_SCAN) && (iss_r < count_r);
  assign hit       = rd_vld_r && (mem_rdata == key_r);
  assign last_beat = rd_vld_r && (rd_pos_r == count_r);

  // low side of the ring is the head in normal order, the tail when reversed
  always_comb begin
    if (in_operation == OP_PUSH_HEAD || in_operation == OP_PUSH_TAIL) begin
      low_side = (in_operation == OP_PUSH_HEAD) != rev_r;
    end else begin
      low_side = (in_operation == OP_DROP_HEAD) != rev_r;
    end
  end

  // ram write for an accepted push
  assign mem_we    = accept && !is_full &&
                     (in_operation == OP_PUSH_HEAD || in_operation == OP_PUSH_TAIL);
  assign mem_waddr = low_side ? ring_dec(front_r) : high_slot;
  assign mem_wdata = in_value;
  assign mem_raddr = ptr_r;

  // next state
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    key_nxt        = key_r;
    ptr_nxt        = ptr_r;
    iss_nxt        = iss_r;
    rd_vld_nxt     = 1'b0;
    rd_pos_nxt     = rd_pos_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_occ_nxt    = out_occ_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_pos_nxt    = '0;
          priority if (in_operation == OP_PUSH_HEAD || in_operation == OP_PUSH_TAIL) begin
            if (is_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
              if (low_side) begin
                front_nxt = ring_dec(front_r);
              end
            end
          end else if (in_operation == OP_DROP_HEAD || in_operation == OP_DROP_TAIL) begin
            if (is_empty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - 1'b1;
              if (low_side) begin
                front_nxt = ring_inc(front_r);
              end
            end
          end else if (in_operation == OP_REVERSE) begin
            rev_nxt = !rev_r;
          end else if (in_operation == OP_SEARCH) begin
            if (is_empty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              // scan from the logical head; result comes from the scan
              out_valid_nxt = 1'b0;
              state_nxt     = S_SCAN;
              key_nxt       = in_value;
              ptr_nxt       = rev_r ? last_slot : front_r;
              iss_nxt       = '0;
            end
          end else begin
            // unused codes leave everything as is
          end
          out_occ_nxt = count_nxt;
        end
      end
      S_SCAN: begin
        if (hit || last_beat) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = hit ? ST_OK : ST_NOTFOUND;
          out_pos_nxt    = hit ? rd_pos_r : '0;
          out_occ_nxt    = count_r;
        end else if (issue) begin
          // one ram read per cycle, stepping in logical order
          rd_vld_nxt = 1'b1;
          rd_pos_nxt = iss_r + 1'b1;
          iss_nxt    = iss_r + 1'b1;
          ptr_nxt    = rev_r ? ring_dec(ptr_r) : ring_inc(ptr_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      rev_r        <= rev_nxt;
      key_r        <= key_nxt;
      ptr_r        <= ptr_nxt;
      iss_r        <= iss_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_pos_r     <= rd_pos_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_occ_r    <= out_occ_nxt;
    end
  end

  assign busy          = (state_r == S_SCAN);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_position  = POS_W'(out_pos_r);
  assign out_occupancy = POS_W'(out_occ_r);

endmodule

// ===== sv/bounded_deque_with_search.sv =====
// bounded deque of signed 32-bit values with linear search over a ring ram
// out_valid follows start in the next cycle for push, drop, reverse and unused
// codes, and a new beat may follow in the next cycle; a search of n elements makes
// up to one ram read per element, with busy high until its result
// reset (synchronous, rst_n low) empties the deque and restores normal order
// results are strobed for one cycle and cannot be stalled
`timescale 1ns / 1ps

module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic [POS_W-1:0]        out_position,
  output logic [POS_W-1:0]        out_occupancy
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // control and search sequencer
  bdq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_occupancy(out_occupancy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // element store
  bdq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ===== sv/bdq_checker.sv =====
// port-level checks for the bounded deque, bound to the top level
// depends on bdq_pkg
`timescale 1ns / 1ps

module bdq_checker
  import bdq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [OP_W-1:0]  in_operation,
  input logic             out_valid,
  input logic [ST_W-1:0]  out_status,
  input logic [POS_W-1:0] out_position
);

  // every beat other than a search answers in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != OP_SEARCH |=> out_valid)
    else $error("non-search beat gave no result in the next cycle");

  // an accepted beat either answers at once or starts a scan
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted beat neither answered nor scanning");

  // no result strobes while a scan is running
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobed during a scan");

  // end of a scan always delivers its result
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without a result");

  // only a successful search reports a position
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_position == '0)
    else $error("position reported on a failed operation");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (.*);
